// ===== hw/rtl/rphw_pkg.sv =====
// Shared types and constants for the ring pixel HSV write path.
package rphw_pkg;

   localparam int PIX_W   = 11;             // signed logical pixel number
   localparam int COLOR_W = 8;              // hue, saturation, value, RGB
   localparam int IDX_W   = 8;              // physical LED index
   localparam int LEN_W   = IDX_W + 1;      // ring length, 1..256
   localparam int CSR_W   = 1;              // register index width

   localparam logic [CSR_W-1:0] CSR_FIRST_LED = 1'b0;
   localparam logic [CSR_W-1:0] CSR_LAST_LED  = 1'b1;

   // Load strobes for the four pipeline stages.
   typedef struct packed {
      logic ld1;
      logic ld2;
      logic ld3;
      logic ld4;
   } stage_en_type;

endpackage

// ===== hw/rtl/rphw_index_pipe.sv =====
// Pixel number to physical LED index: pipelined signed modulo and mapping.
module rphw_index_pipe
   import rphw_pkg::*;
#(
   parameter int MAX_LEDS = 256
) (
   input  logic                    clock,
   input  stage_en_type            stage_en,
   input  logic [IDX_W-1:0]        first_led,
   input  logic [IDX_W-1:0]        last_led,
   input  logic signed [PIX_W-1:0] pixel_number,
   output logic [IDX_W-1:0]        led_index
);

   localparam int DIV_W = LEN_W + PIX_W;

   // One restoring step: subtract len << k when it fits.
   function automatic logic [PIX_W-1:0] rem_step(input logic [PIX_W-1:0] r,
                                                 input logic [LEN_W-1:0] len,
                                                 input int unsigned k);
      logic [DIV_W-1:0] d;
      logic [DIV_W-1:0] rx;
      d  = DIV_W'(len) << k;
      rx = DIV_W'(r);
      if (rx >= d) begin
         rx = rx - d;
      end
      return rx[PIX_W-1:0];
   endfunction

   logic             desc_in;
   logic [IDX_W-1:0] diff_in;
   logic [LEN_W-1:0] span_in;
   logic [LEN_W-1:0] len_in;
   logic             neg_in;
   logic [PIX_W-1:0] pix_u;
   logic [PIX_W-1:0] mag_in;

   logic [PIX_W-1:0] s1_rem_ff, s2_rem_ff, s3_rem_ff;
   logic [PIX_W-1:0] s2_rem_in, s3_rem_in, s4_rem;
   logic [LEN_W-1:0] s1_len_ff, s2_len_ff, s3_len_ff;
   logic             s1_neg_ff, s2_neg_ff, s3_neg_ff;
   logic             s1_desc_ff, s2_desc_ff, s3_desc_ff;
   logic [IDX_W-1:0] s1_first_ff, s2_first_ff, s3_first_ff;
   logic [LEN_W-1:0] pos;
   logic [IDX_W-1:0] led_index_ff, led_index_in;

   always_comb begin
      desc_in = first_led > last_led;
      diff_in = desc_in ? (first_led - last_led) : (last_led - first_led);
      span_in = LEN_W'(diff_in) + LEN_W'(1);
      len_in  = (span_in > LEN_W'(MAX_LEDS)) ? LEN_W'(MAX_LEDS) : span_in;
      pix_u   = pixel_number;
      neg_in  = pix_u[PIX_W-1];
      // -1024 negates to the unsigned pattern 1024, which is what we want
      mag_in  = neg_in ? (~pix_u + PIX_W'(1)) : pix_u;
   end

   always_comb begin
      s2_rem_in = s1_rem_ff;
      for (int i = 0; i < 4; i++) begin
         s2_rem_in = rem_step(s2_rem_in, s1_len_ff, PIX_W - 1 - i);
      end
      s3_rem_in = s2_rem_ff;
      for (int i = 4; i < 8; i++) begin
         s3_rem_in = rem_step(s3_rem_in, s2_len_ff, PIX_W - 1 - i);
      end
      s4_rem = s3_rem_ff;
      for (int i = 8; i < PIX_W; i++) begin
         s4_rem = rem_step(s4_rem, s3_len_ff, PIX_W - 1 - i);
      end
      // remainder of the magnitude; fold back for negative numbers
      if (s3_neg_ff && (s4_rem != '0)) begin
         pos = s3_len_ff - LEN_W'(s4_rem);
      end else begin
         pos = LEN_W'(s4_rem);
      end
      if (s3_desc_ff) begin
         led_index_in = s3_first_ff - pos[IDX_W-1:0];
      end else begin
         led_index_in = s3_first_ff + pos[IDX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en.ld1) begin
         s1_rem_ff   <= mag_in;
         s1_len_ff   <= len_in;
         s1_neg_ff   <= neg_in;
         s1_desc_ff  <= desc_in;
         s1_first_ff <= first_led;
      end
      if (stage_en.ld2) begin
         s2_rem_ff   <= s2_rem_in;
         s2_len_ff   <= s1_len_ff;
         s2_neg_ff   <= s1_neg_ff;
         s2_desc_ff  <= s1_desc_ff;
         s2_first_ff <= s1_first_ff;
      end
      if (stage_en.ld3) begin
         s3_rem_ff   <= s3_rem_in;
         s3_len_ff   <= s2_len_ff;
         s3_neg_ff   <= s2_neg_ff;
         s3_desc_ff  <= s2_desc_ff;
         s3_first_ff <= s2_first_ff;
      end
      if (stage_en.ld4) begin
         led_index_ff <= led_index_in;
      end
   end

   assign led_index = led_index_ff;

endmodule

// ===== hw/rtl/rphw_color_pipe.sv =====
// HSV to RGB: six hue sectors, products scaled by 1/256, over four stages.
module rphw_color_pipe
   import rphw_pkg::*;
(
   input  logic               clock,
   input  stage_en_type       stage_en,
   input  logic [COLOR_W-1:0] hue,
   input  logic [COLOR_W-1:0] saturation,
   input  logic [COLOR_W-1:0] brightness_value,
   output logic [COLOR_W-1:0] red,
   output logic [COLOR_W-1:0] green,
   output logic [COLOR_W-1:0] blue
);

   localparam int H6_W   = COLOR_W + 3;     // hue * 6
   localparam int SEC_W  = H6_W - COLOR_W;  // sector number
   localparam int ONE_W  = COLOR_W + 1;     // holds 256
   localparam int PROD_W = COLOR_W + ONE_W;

   localparam logic [ONE_W-1:0] ONE = ONE_W'(1) << COLOR_W;

   localparam logic [SEC_W-1:0] SEC_RED_YEL  = 3'd0;
   localparam logic [SEC_W-1:0] SEC_YEL_GRN  = 3'd1;
   localparam logic [SEC_W-1:0] SEC_GRN_CYN  = 3'd2;
   localparam logic [SEC_W-1:0] SEC_CYN_BLU  = 3'd3;
   localparam logic [SEC_W-1:0] SEC_BLU_MAG  = 3'd4;

   logic [H6_W-1:0]    s1_h6_ff;
   logic [COLOR_W-1:0] s1_s_ff, s1_v_ff;

   logic [COLOR_W-1:0] frac;
   logic [PROD_W-1:0]  p_prod, sf_prod, st_prod;
   logic [SEC_W-1:0]   s2_sec_ff, s3_sec_ff;
   logic               s2_grey_ff, s3_grey_ff;
   logic [COLOR_W-1:0] s2_v_ff, s3_v_ff;
   logic [COLOR_W-1:0] s2_p_ff, s3_p_ff;
   logic [COLOR_W-1:0] s2_sf_ff, s2_st_ff;

   logic [PROD_W-1:0]  q_prod, t_prod;
   logic [COLOR_W-1:0] s3_q_ff, s3_t_ff;

   logic [COLOR_W-1:0] red_ff, green_ff, blue_ff;
   logic [COLOR_W-1:0] red_in, green_in, blue_in;

   always_comb begin
      frac    = s1_h6_ff[COLOR_W-1:0];
      p_prod  = PROD_W'(s1_v_ff) * PROD_W'(ONE - ONE_W'(s1_s_ff));
      sf_prod = PROD_W'(s1_s_ff) * PROD_W'(frac);
      st_prod = PROD_W'(s1_s_ff) * PROD_W'(ONE - ONE_W'(frac));
      q_prod  = PROD_W'(s2_v_ff) * PROD_W'(ONE - ONE_W'(s2_sf_ff));
      t_prod  = PROD_W'(s2_v_ff) * PROD_W'(ONE - ONE_W'(s2_st_ff));
   end

   always_comb begin
      if (s3_grey_ff) begin
         red_in   = s3_v_ff;
         green_in = s3_v_ff;
         blue_in  = s3_v_ff;
      end else begin
         unique case (s3_sec_ff)
            SEC_RED_YEL: begin
               red_in = s3_v_ff; green_in = s3_t_ff; blue_in = s3_p_ff;
            end
            SEC_YEL_GRN: begin
               red_in = s3_q_ff; green_in = s3_v_ff; blue_in = s3_p_ff;
            end
            SEC_GRN_CYN: begin
               red_in = s3_p_ff; green_in = s3_v_ff; blue_in = s3_t_ff;
            end
            SEC_CYN_BLU: begin
               red_in = s3_p_ff; green_in = s3_q_ff; blue_in = s3_v_ff;
            end
            SEC_BLU_MAG: begin
               red_in = s3_t_ff; green_in = s3_p_ff; blue_in = s3_v_ff;
            end
            default: begin
               red_in = s3_v_ff; green_in = s3_p_ff; blue_in = s3_q_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en.ld1) begin
         s1_h6_ff <= H6_W'(hue) * H6_W'(6);
         s1_s_ff  <= saturation;
         s1_v_ff  <= brightness_value;
      end
      if (stage_en.ld2) begin
         s2_sec_ff  <= s1_h6_ff[H6_W-1:COLOR_W];
         s2_grey_ff <= s1_s_ff == '0;
         s2_v_ff    <= s1_v_ff;
         s2_p_ff    <= p_prod[2*COLOR_W-1:COLOR_W];
         s2_sf_ff   <= sf_prod[2*COLOR_W-1:COLOR_W];
         s2_st_ff   <= st_prod[2*COLOR_W-1:COLOR_W];
      end
      if (stage_en.ld3) begin
         s3_sec_ff  <= s2_sec_ff;
         s3_grey_ff <= s2_grey_ff;
         s3_v_ff    <= s2_v_ff;
         s3_p_ff    <= s2_p_ff;
         s3_q_ff    <= q_prod[2*COLOR_W-1:COLOR_W];
         s3_t_ff    <= t_prod[2*COLOR_W-1:COLOR_W];
      end
      if (stage_en.ld4) begin
         red_ff   <= red_in;
         green_ff <= green_in;
         blue_ff  <= blue_in;
      end
   end

   assign red   = red_ff;
   assign green = green_ff;
   assign blue  = blue_ff;

endmodule

// ===== hw/rtl/ring_pixel_hsv_write.sv =====
// Top level of the ring pixel HSV write path: registers, stage control, datapaths.
//
//   channel  direction  handshake              payload
//   req      in         req_valid/req_ready    pixel_number, hue, saturation,
//                                              brightness_value
//   rsp      out        rsp_valid/rsp_ready    led_index, red, green, blue
//   csr      in         csr_valid/csr_ready    csr_index, csr_data
//
// Four register stages; a result passes through all four after a transfer in, and
// one item per cycle is taken unless a stalled output backs up to req_ready. The
// modulo by ring length (a restoring divider spread over stages two to four)
// sets the depth.
// Synchronous reset empties the pipeline and sets first_led 0, last_led 255.
// Each stage loads when empty or when the one after it moves, so bubbles
// close up behind a stalled output and nothing is dropped or repeated.
module ring_pixel_hsv_write
   import rphw_pkg::*;
#(
   parameter int MAX_LEDS = 256
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic signed [PIX_W-1:0] req_pixel_number,
   input  logic [COLOR_W-1:0]      req_hue,
   input  logic [COLOR_W-1:0]      req_saturation,
   input  logic [COLOR_W-1:0]      req_brightness_value,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [IDX_W-1:0]        rsp_led_index,
   output logic [COLOR_W-1:0]      rsp_red,
   output logic [COLOR_W-1:0]      rsp_green,
   output logic [COLOR_W-1:0]      rsp_blue,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CSR_W-1:0]        csr_index,
   input  logic [IDX_W-1:0]        csr_data
);

   logic [IDX_W-1:0] first_led_ff, last_led_ff;
   logic             v1_ff, v2_ff, v3_ff, v4_ff;
   logic             rdy1, rdy2, rdy3, rdy4;
   stage_en_type     stage_en;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         first_led_ff <= '0;
         last_led_ff  <= '1;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_FIRST_LED: first_led_ff <= csr_data;
            CSR_LAST_LED:  last_led_ff  <= csr_data;
            default:       ;
         endcase
      end
   end

   always_comb begin
      rdy4 = !v4_ff || rsp_ready;
      rdy3 = !v3_ff || rdy4;
      rdy2 = !v2_ff || rdy3;
      rdy1 = !v1_ff || rdy2;
      stage_en.ld1 = rdy1;
      stage_en.ld2 = rdy2;
      stage_en.ld3 = rdy3;
      stage_en.ld4 = rdy4;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= req_valid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
         if (rdy4) v4_ff <= v3_ff;
      end
   end

   assign req_ready = rdy1;
   assign rsp_valid = v4_ff;

   rphw_index_pipe #(
      .MAX_LEDS(MAX_LEDS)
   ) u_index (
      .clock        (clock),
      .stage_en     (stage_en),
      .first_led    (first_led_ff),
      .last_led     (last_led_ff),
      .pixel_number (req_pixel_number),
      .led_index    (rsp_led_index)
   );

   rphw_color_pipe u_color (
      .clock            (clock),
      .stage_en         (stage_en),
      .hue              (req_hue),
      .saturation       (req_saturation),
      .brightness_value (req_brightness_value),
      .red              (rsp_red),
      .green            (rsp_green),
      .blue             (rsp_blue)
   );

endmodule

// ===== hw/rtl/rphw_checker.sv =====
// Port-level checks for the ring pixel HSV write path, bound to the top level.
module rphw_checker
   import rphw_pkg::*;
(
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_ready,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input logic [IDX_W-1:0]        rsp_led_index,
   input logic [COLOR_W-1:0]      rsp_red,
   input logic [COLOR_W-1:0]      rsp_green,
   input logic [COLOR_W-1:0]      rsp_blue
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp_valid dropped before transfer");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_led_index) && $stable(rsp_red)
                                  && $stable(rsp_green) && $stable(rsp_blue))
      else $error("rsp payload changed while stalled");

   // a free-running output side never back-pressures the input
   a_no_stall: assert property (@(posedge clock)
      rsp_ready |-> req_ready)
      else $error("req_ready low while rsp_ready high");

   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) ##1 rsp_ready ##1 rsp_ready ##1 rsp_ready
      |=> rsp_valid)
      else $error("result missing four cycles after transfer");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid high right after reset");

endmodule

bind ring_pixel_hsv_write rphw_checker u_rphw_checker (.*);

// ===== sim/tb_ring_pixel_hsv_write.sv =====
// Self-checking testbench for the ring pixel HSV write path.
`timescale 1ns / 1ps

module tb_ring_pixel_hsv_write;
   import rphw_pkg::*;

   localparam int RING_MAX    = 256;
   localparam int CYCLE_LIMIT = 200000;
   localparam int PHASES      = 12;
   localparam int PHASE_ITEMS = 145;

   typedef struct packed {
      logic signed [PIX_W-1:0] pixel;
      logic [COLOR_W-1:0]      hue;
      logic [COLOR_W-1:0]      sat;
      logic [COLOR_W-1:0]      val;
   } pixel_req_type;

   typedef struct packed {
      logic [IDX_W-1:0]   led;
      logic [COLOR_W-1:0] red;
      logic [COLOR_W-1:0] green;
      logic [COLOR_W-1:0] blue;
   } led_write_type;

   // hue circle split into six sectors of 256/6 steps
   typedef enum int {SEC_RY, SEC_YG, SEC_GC, SEC_CB, SEC_BM, SEC_MR} hue_sector_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   logic signed [PIX_W-1:0] req_pixel_number = '0;
   logic [COLOR_W-1:0]      req_hue = '0;
   logic [COLOR_W-1:0]      req_saturation = '0;
   logic [COLOR_W-1:0]      req_brightness_value = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic [IDX_W-1:0]        rsp_led_index;
   logic [COLOR_W-1:0]      rsp_red;
   logic [COLOR_W-1:0]      rsp_green;
   logic [COLOR_W-1:0]      rsp_blue;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   logic [CSR_W-1:0]        csr_index = '0;
   logic [IDX_W-1:0]        csr_data = '0;

   pixel_req_type    pixel_q[$];
   led_write_type    led_write_q[$];
   logic [IDX_W-1:0] ring_first = 8'd0;
   logic [IDX_W-1:0] ring_last  = 8'd255;
   logic             req_fire = 1'b0;
   int               send_idle_pct = 32;
   int               rcv_stall_pct = 57;
   int               fail_count = 0;
   int               cycle_count = 0;

   ring_pixel_hsv_write #(.MAX_LEDS(RING_MAX)) i_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_pixel_number     (req_pixel_number),
      .req_hue              (req_hue),
      .req_saturation       (req_saturation),
      .req_brightness_value (req_brightness_value),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_led_index        (rsp_led_index),
      .rsp_red              (rsp_red),
      .rsp_green            (rsp_green),
      .rsp_blue             (rsp_blue),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_data             (csr_data)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   function automatic int ring_length(input logic [IDX_W-1:0] first,
                                      input logic [IDX_W-1:0] last);
      int span;
      span = (first > last) ? int'(first) - int'(last) + 1 : int'(last) - int'(first) + 1;
      return (span > RING_MAX) ? RING_MAX : span;
   endfunction

   // Physical LED index and RGB color for one pixel under the given ring setup.
   function automatic led_write_type led_write_for(input pixel_req_type px,
                                                   input logic [IDX_W-1:0] first,
                                                   input logic [IDX_W-1:0] last);
      int len, n, pos, idx;
      int h6, f, s, v, p, q, t;
      led_write_type w;
      len = ring_length(first, last);
      n   = $signed(px.pixel);
      pos = ((n % len) + len) % len;
      idx = (first > last) ? int'(first) - pos : int'(first) + pos;
      w.led = idx[IDX_W-1:0];
      s = px.sat;
      v = px.val;
      if (s == 0) begin
         w.red   = v[7:0];
         w.green = v[7:0];
         w.blue  = v[7:0];
      end else begin
         h6 = int'(px.hue) * 6;
         f  = h6 & 255;
         p  = (v * (256 - s)) >> 8;
         q  = (v * (256 - ((s * f) >> 8))) >> 8;
         t  = (v * (256 - ((s * (256 - f)) >> 8))) >> 8;
         case (hue_sector_type'(h6 >> 8))
            SEC_RY: begin w.red = v[7:0]; w.green = t[7:0]; w.blue = p[7:0]; end
            SEC_YG: begin w.red = q[7:0]; w.green = v[7:0]; w.blue = p[7:0]; end
            SEC_GC: begin w.red = p[7:0]; w.green = v[7:0]; w.blue = t[7:0]; end
            SEC_CB: begin w.red = p[7:0]; w.green = q[7:0]; w.blue = v[7:0]; end
            SEC_BM: begin w.red = t[7:0]; w.green = p[7:0]; w.blue = v[7:0]; end
            default: begin w.red = v[7:0]; w.green = p[7:0]; w.blue = q[7:0]; end
         endcase
      end
      return w;
   endfunction

   function automatic pixel_req_type make_pixel(input int pix, input int h, input int s,
                                                input int v);
      pixel_req_type px;
      px.pixel = pix[PIX_W-1:0];
      px.hue   = h[7:0];
      px.sat   = s[7:0];
      px.val   = v[7:0];
      return px;
   endfunction

   // Mix of full-range, near-ring, extreme and ring-multiple pixel numbers.
   function automatic pixel_req_type random_pixel(input int len);
      int pick, pix, s, v;
      pick = $urandom_range(0, 99);
      if (pick < 50)
         pix = int'($urandom_range(0, 2047)) - 1024;
      else if (pick < 80)
         pix = int'($urandom_range(0, 2 * len)) - len;
      else if (pick < 90)
         pix = pick[0] ? 1023 : -1024;
      else
         pix = len * (int'($urandom_range(0, 8)) - 4) + int'($urandom_range(0, 2)) - 1;
      pick = $urandom_range(0, 99);
      s = (pick < 15) ? 0 : (pick < 25) ? 255 : int'($urandom_range(0, 255));
      pick = $urandom_range(0, 99);
      v = (pick < 10) ? 0 : (pick < 20) ? 255 : int'($urandom_range(0, 255));
      return make_pixel(pix, int'($urandom_range(0, 255)), s, v);
   endfunction

   task automatic write_reg(input logic [CSR_W-1:0] idx, input logic [IDX_W-1:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_FIRST_LED)
         ring_first = val;
      else
         ring_last = val;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic drain();
      while (pixel_q.size() != 0 || req_valid || led_write_q.size() != 0)
         @(posedge clock);
   endtask

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endtask

   // Result check and input transfer bookkeeping, both at the rising edge.
   always @(posedge clock) begin : watch_rsp
      led_write_type want;
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
      if (!reset && rsp_valid && rsp_ready) begin
         if (led_write_q.size() == 0) begin
            $error("unexpected LED write to index %0d", rsp_led_index);
            fail_count++;
         end else begin
            want = led_write_q.pop_front();
            check_field("led_index", want.led, rsp_led_index);
            check_field("red", want.red, rsp_red);
            check_field("green", want.green, rsp_green);
            check_field("blue", want.blue, rsp_blue);
         end
      end
      if (!reset && req_valid && req_ready)
         led_write_q.push_back(led_write_for({req_pixel_number, req_hue, req_saturation,
                                              req_brightness_value}, ring_first, ring_last));
      req_fire <= !reset && req_valid && req_ready;
   end

   always @(negedge clock) begin : drive_req
      pixel_req_type nxt;
      if (!reset && (!req_valid || req_fire)) begin
         if (pixel_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            nxt = pixel_q.pop_front();
            req_valid            <= 1'b1;
            req_pixel_number     <= nxt.pixel;
            req_hue              <= nxt.hue;
            req_saturation       <= nxt.sat;
            req_brightness_value <= nxt.val;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= rcv_stall_pct);
   end

   initial begin : stimulus
      int ph, n;
      logic [IDX_W-1:0] first, last;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset ring 0..255: wrap extremes, sector edges, gray, black
      pixel_q.push_back(make_pixel(0, 0, 0, 0));
      pixel_q.push_back(make_pixel(-1, 0, 0, 255));
      pixel_q.push_back(make_pixel(1023, 255, 255, 255));
      pixel_q.push_back(make_pixel(-1024, 0, 255, 255));
      pixel_q.push_back(make_pixel(255, 42, 255, 255));
      pixel_q.push_back(make_pixel(256, 43, 255, 255));
      pixel_q.push_back(make_pixel(511, 85, 200, 255));
      pixel_q.push_back(make_pixel(-256, 86, 255, 128));
      pixel_q.push_back(make_pixel(-257, 127, 255, 255));
      pixel_q.push_back(make_pixel(512, 128, 255, 255));
      pixel_q.push_back(make_pixel(1, 170, 255, 255));
      pixel_q.push_back(make_pixel(2, 171, 255, 255));
      pixel_q.push_back(make_pixel(3, 213, 255, 255));
      pixel_q.push_back(make_pixel(4, 214, 255, 255));
      pixel_q.push_back(make_pixel(5, 255, 1, 255));
      pixel_q.push_back(make_pixel(6, 100, 255, 0));
      pixel_q.push_back(make_pixel(-2, 30, 128, 200));
      pixel_q.push_back(make_pixel(7, 0, 1, 1));
      pixel_q.push_back(make_pixel(1000, 200, 0, 17));
      pixel_q.push_back(make_pixel(-1000, 250, 254, 254));
      drain();

      for (ph = 1; ph <= PHASES; ph++) begin
         if (ph <= 4) begin
            send_idle_pct = 32;
            rcv_stall_pct = 57;
         end else if (ph <= 8) begin
            send_idle_pct = 57;
            rcv_stall_pct = 32;
         end else begin
            send_idle_pct = 0;
            rcv_stall_pct = 0;
         end
         // ascending, descending, single-LED and offset rings, then random ones
         case (ph)
            1:  begin first = 8'd255; last = 8'd0;   end
            2:  begin first = 8'd77;  last = 8'd77;  end
            3:  begin first = 8'd10;  last = 8'd40;  end
            4:  begin first = 8'd0;   last = 8'd255; end
            5:  begin first = 8'd200; last = 8'd17;  end
            6:  begin first = 8'd0;   last = 8'd0;   end
            7:  begin first = 8'd1;   last = 8'd255; end
            8:  begin first = 8'd255; last = 8'd255; end
            9:  begin first = 8'd255; last = 8'd1;   end
            10: begin first = 8'd0;   last = 8'd254; end
            default: begin
               first = $urandom_range(0, 255);
               last  = $urandom_range(0, 255);
            end
         endcase
         write_reg(CSR_FIRST_LED, first);
         write_reg(CSR_LAST_LED, last);
         n = ring_length(ring_first, ring_last);
         repeat (PHASE_ITEMS) pixel_q.push_back(random_pixel(n));
         // sender holds off here until every LED write of the phase is back
         drain();
      end

      repeat (16) @(posedge clock);
      if (fail_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
